/* rtl/core/aald_pkg.sv */
// Shared constants for the audio activity level detector.
package aald_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int COEFF_W    = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_THRESHOLD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING_COEFF   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESTART_ON_LOUD   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESTART_ON_SILENT = 2'd3;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 15'd328;
  localparam logic [COEFF_W-1:0] COEFF_RESET     = 17'd6554;
  localparam logic [COEFF_W-1:0] COEFF_ONE       = 17'd65536;

  localparam int MUL_CNT_W = 5;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST_BIT = 5'd16;

endpackage

/* rtl/core/audio_activity_level_detector.sv */
// Frame level detector: abs-sum accumulate, serial divide, serial multiply IIR, threshold.
// A sample that does not end a frame is absorbed while idle and gives no result.
// A frame-end beat holds off input through 15+FRAC_BITS divide steps, a diff step,
// 17 multiply steps of the shift-add unit, then apply and compare, until the result loads.
// A muted frame-end beat clears the average and skips to compare. The result waits in an output register.
// Reset (rst_n low, synchronous) clears accumulators, average, decision and output valid.
module audio_activity_level_detector #(
  parameter int MAX_FRAME = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [aald_pkg::IN_TDATA_W-1:0]        in_tdata,   // sample[15:0]
  input  logic                                   in_tlast,
  input  logic                                   in_tuser,   // muted
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // loud[0], changed[1], loud pulse[2], silent pulse[3], level[18:4]
  output logic [aald_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                   cfg_we,
  input  logic [aald_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [aald_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CW   = $clog2(MAX_FRAME + 1);
  localparam int SW   = 16 + $clog2(MAX_FRAME);
  localparam int AW   = aald_pkg::LEVEL_W + FRAC_BITS;
  localparam int DCW  = $clog2(AW);
  localparam int PW   = AW + aald_pkg::COEFF_W;
  localparam int LW   = aald_pkg::LEVEL_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic [SW-1:0]                    sum_r, sum_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [AW-1:0]                    avg_r, avg_nxt;
  logic                             loud_r, loud_nxt;
  logic [CW-1:0]                    rem_r, rem_nxt;
  logic [AW-1:0]                    quo_r, quo_nxt;
  logic [CW-1:0]                    dvs_r, dvs_nxt;
  logic [DCW-1:0]                   dcnt_r, dcnt_nxt;
  logic [AW-1:0]                    mag_r, mag_nxt;
  logic                             ge_r, ge_nxt;
  logic [PW-1:0]                    acc_r, acc_nxt;
  logic [aald_pkg::COEFF_W-1:0]     mc_r, mc_nxt;
  logic [aald_pkg::MUL_CNT_W-1:0]   mcnt_r, mcnt_nxt;
  logic                             ov_r, ov_nxt;
  logic                             o_loud_r, o_loud_nxt;
  logic                             o_chg_r, o_chg_nxt;
  logic                             o_rl_r, o_rl_nxt;
  logic                             o_rs_r, o_rs_nxt;
  logic [LW-1:0]                    o_lvl_r, o_lvl_nxt;
  logic [LW-1:0]                    thr_r, thr_nxt;
  logic [aald_pkg::COEFF_W-1:0]     coeff_r, coeff_nxt;
  logic                             rol_r, rol_nxt;
  logic                             ros_r, ros_nxt;

  logic                             in_acc;
  logic [aald_pkg::SAMPLE_W-1:0]    smp;
  logic [aald_pkg::SAMPLE_W-1:0]    smp_neg;
  logic [LW-1:0]                    abs15;
  logic                             take;
  logic [SW-1:0]                    sum_upd;
  logic [CW-1:0]                    cnt_upd;
  logic [CW:0]                      shifted;
  logic [CW+1:0]                    trial;
  logic [AW-1:0]                    mean;
  logic [AW:0]                      dif;
  logic [AW:0]                      dif_neg;
  logic [AW-1:0]                    step;
  logic [AW-1:0]                    thr_ext;
  logic                             now_loud;
  logic                             chg;
  logic                             load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = {5'b0, o_lvl_r, o_rs_r, o_rl_r, o_chg_r, o_loud_r};

  assign smp     = in_tdata;
  assign smp_neg = ~smp + 1'b1;
  assign abs15   = smp[15] ? ((smp == 16'h8000) ? 15'h7FFF : smp_neg[LW-1:0]) : smp[LW-1:0];
  assign take    = (cnt_r < CW'(MAX_FRAME));
  assign sum_upd = take ? (sum_r + SW'(abs15)) : sum_r;
  assign cnt_upd = take ? (cnt_r + 1'b1) : cnt_r;

  assign shifted = {rem_r, quo_r[AW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};

  assign mean    = (dvs_r == '0) ? '0 : quo_r;
  assign dif     = {1'b0, mean} - {1'b0, avg_r};
  assign dif_neg = ~dif + 1'b1;
  assign step    = acc_r[AW+15:16];

  assign thr_ext  = {thr_r, {FRAC_BITS{1'b0}}};
  assign now_loud = (avg_r > thr_ext);
  assign chg      = now_loud ^ loud_r;
  assign load_out = (state_r == ST_DONE) && (!ov_r || out_tready);

  always_comb begin
    thr_nxt   = thr_r;
    coeff_nxt = coeff_r;
    rol_nxt   = rol_r;
    ros_nxt   = ros_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        aald_pkg::CFG_LEVEL_THRESHOLD:   thr_nxt   = cfg_wdata[LW-1:0];
        aald_pkg::CFG_SMOOTHING_COEFF:   coeff_nxt = cfg_wdata;
        aald_pkg::CFG_RESTART_ON_LOUD:   rol_nxt   = cfg_wdata[0];
        aald_pkg::CFG_RESTART_ON_SILENT: ros_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    avg_nxt    = avg_r;
    loud_nxt   = loud_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    dcnt_nxt   = dcnt_r;
    mag_nxt    = mag_r;
    ge_nxt     = ge_r;
    acc_nxt    = acc_r;
    mc_nxt     = mc_r;
    mcnt_nxt   = mcnt_r;
    ov_nxt     = ov_r & ~out_tready;
    o_loud_nxt = o_loud_r;
    o_chg_nxt  = o_chg_r;
    o_rl_nxt   = o_rl_r;
    o_rs_nxt   = o_rs_r;
    o_lvl_nxt  = o_lvl_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sum_nxt = sum_upd;
          cnt_nxt = cnt_upd;
          if (in_tlast) begin
            sum_nxt  = '0;
            cnt_nxt  = '0;
            rem_nxt  = CW'(sum_upd[SW-1:LW]);
            quo_nxt  = {sum_upd[LW-1:0], {FRAC_BITS{1'b0}}};
            dvs_nxt  = cnt_upd;
            dcnt_nxt = DCW'(AW - 1);
            if (in_tuser) begin
              avg_nxt   = '0;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        rem_nxt = trial[CW+1] ? shifted[CW-1:0] : trial[CW-1:0];
        quo_nxt = {quo_r[AW-2:0], ~trial[CW+1]};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ge_nxt   = ~dif[AW];
        mag_nxt  = dif[AW] ? dif_neg[AW-1:0] : dif[AW-1:0];
        acc_nxt  = '0;
        mc_nxt   = (coeff_r > aald_pkg::COEFF_ONE) ? aald_pkg::COEFF_ONE : coeff_r;
        mcnt_nxt = aald_pkg::MUL_LAST_BIT;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        acc_nxt  = {acc_r[PW-2:0], 1'b0} + (mc_r[aald_pkg::COEFF_W-1] ? PW'(mag_r) : '0);
        mc_nxt   = {mc_r[aald_pkg::COEFF_W-2:0], 1'b0};
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == '0) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        avg_nxt   = ge_r ? (avg_r + step) : (avg_r - step);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          ov_nxt     = 1'b1;
          o_loud_nxt = now_loud;
          o_chg_nxt  = chg;
          o_rl_nxt   = chg & now_loud & rol_r;
          o_rs_nxt   = chg & ~now_loud & ros_r;
          o_lvl_nxt  = avg_r[AW-1:FRAC_BITS];
          loud_nxt   = now_loud;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      avg_r   <= '0;
      loud_r  <= 1'b0;
      ov_r    <= 1'b0;
      thr_r   <= aald_pkg::THRESHOLD_RESET;
      coeff_r <= aald_pkg::COEFF_RESET;
      rol_r   <= 1'b0;
      ros_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      avg_r   <= avg_nxt;
      loud_r  <= loud_nxt;
      ov_r    <= ov_nxt;
      thr_r   <= thr_nxt;
      coeff_r <= coeff_nxt;
      rol_r   <= rol_nxt;
      ros_r   <= ros_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    dcnt_r   <= dcnt_nxt;
    mag_r    <= mag_nxt;
    ge_r     <= ge_nxt;
    acc_r    <= acc_nxt;
    mc_r     <= mc_nxt;
    mcnt_r   <= mcnt_nxt;
    o_loud_r <= o_loud_nxt;
    o_chg_r  <= o_chg_nxt;
    o_rl_r   <= o_rl_nxt;
    o_rs_r   <= o_rs_nxt;
    o_lvl_r  <= o_lvl_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_FRAME))
    else $error("sample count beyond frame limit");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast && !in_tuser) |=> (state_r == ST_DIV) && (dvs_r != '0))
    else $error("frame end did not start divide with nonzero count");

  a_muted_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast && in_tuser) |=> (state_r == ST_DONE) && (avg_r == '0))
    else $error("muted frame end did not clear average");

  a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> (o_loud_r == loud_r) && (o_chg_r == (loud_r != $past(loud_r))))
    else $error("result flags disagree with decision state");

endmodule

/* dv/audio_activity_level_detector_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the activity level detector: directed and random frames.
module audio_activity_level_detector_test;

  localparam int MAX_FRAME   = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int COEFF_SHIFT = 16;
  localparam int SETTLE      = FRAC_BITS + 44;
  localparam int MAX_CYCLES  = 1000000;
  localparam int SHOW_MAX    = 10;

  typedef enum int unsigned {AMP_QUIET, AMP_MID, AMP_FULL} amp_t;

  typedef struct packed {
    logic [aald_pkg::LEVEL_W-1:0] level;
    logic                         silent_pulse;
    logic                         loud_pulse;
    logic                         changed;
    logic                         loud;
  } level_report_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [aald_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tlast = 1'b0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [aald_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_we = 1'b0;
  logic [aald_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [aald_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic [aald_pkg::LEVEL_W-1:0] thr_q = aald_pkg::THRESHOLD_RESET;
  logic [aald_pkg::COEFF_W-1:0] coeff_q = aald_pkg::COEFF_RESET;
  logic               loud_en = 1'b0;
  logic               silent_en = 1'b0;
  longint unsigned    frame_sum = 0;
  int unsigned        frame_cnt = 0;
  longint unsigned    avg_level = 0;
  logic               prev_loud = 1'b0;
  level_report_t      report_q[$];
  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;
  bit                 steady = 1'b0;

  audio_activity_level_detector #(
    .MAX_FRAME(MAX_FRAME),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("** audio_activity_level_detector: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_sample(input amp_t amp);
    logic [15:0] m;
    case (amp)
      AMP_QUIET: m = 16'($urandom_range(0, 255));
      AMP_MID:   m = 16'($urandom_range(0, 4095));
      default:   return 16'($urandom);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic void apply_reg(input logic [aald_pkg::CFG_ADDR_W-1:0] a,
                                    input logic [aald_pkg::CFG_DATA_W-1:0] d);
    case (a)
      aald_pkg::CFG_LEVEL_THRESHOLD:   thr_q = d[aald_pkg::LEVEL_W-1:0];
      aald_pkg::CFG_SMOOTHING_COEFF:   coeff_q = d[aald_pkg::COEFF_W-1:0];
      aald_pkg::CFG_RESTART_ON_LOUD:   loud_en = d[0];
      aald_pkg::CFG_RESTART_ON_SILENT: silent_en = d[0];
      default: ;
    endcase
  endfunction

  function automatic void absorb_sample(input logic [15:0] smp, input logic last,
                                        input logic mute);
    longint unsigned mag, mean, k;
    level_report_t r;
    if (frame_cnt < MAX_FRAME) begin
      mag = smp[15] ? 64'd65536 - 64'(smp) : 64'(smp);
      if (mag > 32767) mag = 32767;
      frame_sum += mag;
      frame_cnt++;
    end
    if (!last) return;
    if (mute) begin
      avg_level = 0;
    end else begin
      mean = (frame_sum << FRAC_BITS) / frame_cnt;
      k = (coeff_q > aald_pkg::COEFF_ONE) ? 64'(aald_pkg::COEFF_ONE) : 64'(coeff_q);
      if (mean >= avg_level) avg_level = avg_level + (((mean - avg_level) * k) >> COEFF_SHIFT);
      else avg_level = avg_level - (((avg_level - mean) * k) >> COEFF_SHIFT);
    end
    frame_sum = 0;
    frame_cnt = 0;
    r.loud = avg_level > (64'(thr_q) << FRAC_BITS);
    r.changed = r.loud != prev_loud;
    r.loud_pulse = r.changed && r.loud && loud_en;
    r.silent_pulse = r.changed && !r.loud && silent_en;
    r.level = aald_pkg::LEVEL_W'(avg_level >> FRAC_BITS);
    prev_loud = r.loud;
    report_q.push_back(r);
  endfunction

  task automatic send_beat(input logic [15:0] smp, input logic last, input logic mute);
    int unsigned g;
    g = steady ? 0 : idle_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tlast <= last;
    in_tuser <= mute;
    do @(posedge clk); while (!in_tready);
    absorb_sample(smp, last, mute);
  endtask

  task automatic send_frame(input int unsigned len, input amp_t amp, input logic mute);
    for (int unsigned i = 1; i < len; i++) send_beat(pick_sample(amp), 1'b0, 1'($urandom));
    send_beat(pick_sample(amp), 1'b1, mute);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aald_pkg::CFG_ADDR_W-1:0] a,
                           input logic [aald_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    apply_reg(a, d);
  endtask

  task automatic configure(input logic [aald_pkg::LEVEL_W-1:0] thr,
                           input logic [aald_pkg::COEFF_W-1:0] k,
                           input logic on_loud, input logic on_silent);
    settle();
    write_reg(aald_pkg::CFG_LEVEL_THRESHOLD, aald_pkg::CFG_DATA_W'(thr));
    write_reg(aald_pkg::CFG_SMOOTHING_COEFF, aald_pkg::CFG_DATA_W'(k));
    write_reg(aald_pkg::CFG_RESTART_ON_LOUD, aald_pkg::CFG_DATA_W'(on_loud));
    write_reg(aald_pkg::CFG_RESTART_ON_SILENT, aald_pkg::CFG_DATA_W'(on_silent));
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_levels();
    send_beat(16'h7FFF, 1'b1, 1'b0);
    send_beat(16'h8000, 1'b1, 1'b0);
    send_beat(16'h0000, 1'b1, 1'b0);
    send_beat(16'hFFFF, 1'b0, 1'b1);
    send_beat(16'h0001, 1'b1, 1'b0);
    send_beat(16'h3039, 1'b1, 1'b1);
  endtask

  task automatic test_restart_pulses();
    configure(15'd1000, aald_pkg::COEFF_ONE, 1'b1, 1'b1);
    send_beat(16'h7FFF, 1'b1, 1'b0);
    send_beat(16'h0010, 1'b1, 1'b0);
    send_beat(16'h8000, 1'b0, 1'b0);
    send_beat(16'h8000, 1'b1, 1'b0);
    send_beat(16'h1234, 1'b1, 1'b1);
    configure(15'h7FFF, 17'h1FFFF, 1'b0, 1'b0);
    send_beat(16'h8000, 1'b1, 1'b0);
    send_beat(16'h7FFF, 1'b1, 1'b0);
    configure(15'd0, 17'd0, 1'b1, 1'b1);
    send_beat(16'h0000, 1'b1, 1'b0);
    send_beat(16'h7FFF, 1'b1, 1'b0);
    send_beat(16'h4000, 1'b1, 1'b1);
    send_beat(16'h7FFF, 1'b1, 1'b0);
  endtask

  task automatic test_frame_overflow();
    configure(15'd0, aald_pkg::COEFF_ONE, 1'b0, 1'b0);
    for (int unsigned i = 0; i < MAX_FRAME; i++) send_beat(pick_sample(AMP_QUIET), 1'b0, 1'b0);
    repeat (5) send_beat(16'h8000, 1'b0, 1'b1);
    send_beat(16'h7FFF, 1'b1, 1'b0);
    send_frame(3, AMP_MID, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned sent, len;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(15'd0, 17'd0, 1'($urandom), 1'($urandom));
        1: configure(15'h7FFF, aald_pkg::COEFF_ONE, 1'b1, 1'b1);
        2: configure(15'($urandom_range(50, 6000)), 17'h1FFFF, 1'b1, 1'b0);
        default: configure(15'($urandom_range(50, 6000)), 17'($urandom_range(1024, 70000)),
                           1'($urandom), 1'($urandom));
      endcase
      steady = (phase % 3) == 2;
      sent = 0;
      while (sent < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        send_frame(len, amp_t'($urandom_range(0, 2)), $urandom_range(0, 9) == 0);
        sent += len;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int unsigned g;
    wait (rst_n);
    forever begin
      g = steady ? 0 : idle_len();
      if (g != 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    level_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = level_report_t'(out_tdata[$bits(level_report_t)-1:0]);
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result beat: tdata=%h", out_tdata);
      end else begin
        want = report_q.pop_front();
        if (got.loud !== want.loud || got.changed !== want.changed ||
            got.loud_pulse !== want.loud_pulse ||
            got.silent_pulse !== want.silent_pulse || got.level !== want.level) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("result mismatch: expected loud=%0d changed=%0d rl=%0d rs=%0d level=%0d",
                     want.loud, want.changed, want.loud_pulse, want.silent_pulse, want.level);
            $display("                      got loud=%0d changed=%0d rl=%0d rs=%0d level=%0d",
                     got.loud, got.changed, got.loud_pulse, got.silent_pulse, got.level);
          end
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_levels();
    test_restart_pulses();
    test_frame_overflow();
    test_random_frames();
    settle();
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("** audio_activity_level_detector: PASSED **");
    end else begin
      $display("** audio_activity_level_detector: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/aald_pkg.sv
rtl/core/audio_activity_level_detector.sv
dv/audio_activity_level_detector_test.sv
